// ===== design/lorentz_multi_peak_residual_defines.svh =====
// Assertion macros for the Lorentzian residual engine.
`ifndef LORENTZ_MULTI_PEAK_RESIDUAL_DEFINES_SVH
`define LORENTZ_MULTI_PEAK_RESIDUAL_DEFINES_SVH
`ifndef SYNTH
`define LRZ_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("lrz assertion failed");
`define LRZ_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("lrz assertion failed");
`else
`define LRZ_ASSERT(lbl, ck, rs, prop)
`define LRZ_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

// ===== design/lrz_pkg.sv =====
// Shared types, constants and helpers for the Lorentzian residual engine.
package lrz_pkg;
  localparam int NUM_PEAKS = 16;
  localparam int IDX_W = 4;
  localparam int SUM_W = 40;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic REG_PEAK_COUNT = 1'b0;
  localparam logic REG_OFFSET     = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   peak_index;
    logic signed [31:0] peak_amplitude;
    logic signed [31:0] peak_center;
    logic signed [31:0] peak_width;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic [30:0]        sigma_value;
    logic               last_point;
  } item_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic [63:0]        chi_square;
    logic               point_last;
    logic               divide_error;
  } result_t;

  typedef struct packed {
    logic                    valid;
    logic signed [31:0]      x;
    logic signed [SUM_W-1:0] sum;
    logic                    err;
  } tok_t;

  typedef struct packed {
    logic signed [31:0] amp;
    logic signed [31:0] ctr;
    logic signed [31:0] wid;
  } peak_t;

  // clamp a quotient magnitude to the signed 32-bit range
  function automatic logic [31:0] sat_mag(logic [31:0] q, logic over, logic neg);
    logic [31:0] lim;
    lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    return (over || (q > lim)) ? lim : q;
  endfunction
endpackage

// ===== design/lorentz_multi_peak_residual.sv =====
// Sum-of-Lorentzian-peaks residual engine, top level.
// A load beat writes one peak into its cell. A data point travels down a
// row of sixteen peak cells; an enabled cell works out its term in three
// shared-multiplier steps, then a 32-step bit-serial divide that is skipped
// on a zero denominator or an overflowing quotient, while a cell past
// peak_count passes the point on in the next cycle. The residual tail then
// does the sigma divide and the chi-square update. One point is in flight
// at a time; the next beat is taken once the previous result sits in the
// output register.
`include "lorentz_multi_peak_residual_defines.svh"
module lorentz_multi_peak_residual (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  lrz_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output lrz_pkg::result_t result,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [31:0]      wr_data
);
  import lrz_pkg::*;

  logic busy;
  logic [4:0] peak_count;
  logic signed [31:0] offset;
  logic signed [31:0] y;
  logic [30:0] sigma;
  logic last;
  tok_t launch;

  logic accept;
  logic done;
  peak_t ld_data;
  tok_t chain [NUM_PEAKS+1];
  logic [NUM_PEAKS:0] tok_live;

  assign accept     = item_valid && !busy;
  assign item_stall = busy;
  assign ld_data    = '{amp: item.peak_amplitude, ctr: item.peak_center,
                        wid: item.peak_width};
  assign chain[0]   = launch;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      peak_count <= 5'd1;
      offset <= '0;
      launch.valid <= 1'b0;
    end else begin
      launch.valid <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_PEAK_COUNT: peak_count <= wr_data[4:0];
          REG_OFFSET:     offset <= wr_data;
          default:        ;
        endcase
      end
      if (accept && item.cmd == CMD_POINT) begin
        busy <= 1'b1;
        launch.valid <= 1'b1;
        launch.x <= item.x_value;
        launch.sum <= '0;
        launch.err <= 1'b0;
        y <= item.y_value;
        sigma <= item.sigma_value;
        last <= item.last_point;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < NUM_PEAKS; k++) begin : g_cell
    lrz_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load_we  (accept && item.cmd == CMD_LOAD && item.peak_index == IDX_W'(k)),
      .load_data(ld_data),
      .en       (peak_count > 5'(k)),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
  end

  for (genvar k = 0; k <= NUM_PEAKS; k++) begin : g_live
    assign tok_live[k] = chain[k].valid;
  end

  lrz_resid u_resid (
    .clk         (clk),
    .rst         (rst),
    .tok_in      (chain[NUM_PEAKS]),
    .offset      (offset),
    .y           (y),
    .sigma       (sigma),
    .last        (last),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result),
    .done        (done)
  );

  `LRZ_ASSERT(a_one_token, clk, rst, $onehot0(tok_live))
  `LRZ_ASSERT(a_point_busy, clk, rst, (accept && item.cmd == CMD_POINT) |=> busy)
  `LRZ_ASSERT(a_busy_clear, clk, rst, $fell(busy) |-> $past(done))
  `LRZ_ASSERT(a_done_busy, clk, rst, done |-> busy)
endmodule

// ===== design/lrz_cell.sv =====
// One peak cell: holds a peak and adds its Lorentzian term to the passing token.
module lrz_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_we,
  input  lrz_pkg::peak_t load_data,
  input  logic          en,
  input  lrz_pkg::tok_t tok_in,
  output lrz_pkg::tok_t tok_out
);
  import lrz_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_DEN, S_CHK, S_DIV, S_ACC
  } state_t;

  state_t state;
  peak_t peak;
  logic signed [31:0] x;
  logic signed [SUM_W-1:0] sum;
  logic err;
  logic [31:0] ud;
  logic [63:0] d2;
  logic [63:0] w2;
  logic [63:0] n;
  logic [66:0] den;
  logic [67:0] rem;
  logic [31:0] nlo;
  logic [31:0] q;
  logic over;
  logic [4:0] cnt;

  logic signed [32:0] diff;
  logic [31:0] ud_in;
  logic [31:0] ua;
  logic [31:0] uw;
  logic neg;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [67:0] shifted;
  logic ge;
  logic [31:0] tmag;
  logic signed [SUM_W-1:0] term;

  assign diff  = 33'(tok_in.x) - 33'(peak.ctr);
  assign ud_in = diff[32] ? 32'(-diff) : diff[31:0];
  assign ua    = peak.amp[31] ? 32'(-peak.amp) : peak.amp;
  assign uw    = peak.wid[31] ? 32'(-peak.wid) : peak.wid;
  assign neg   = peak.amp[31] ^ peak.wid[31];

  always_comb begin
    case (state)
      S_MUL0: begin mul_a = ud; mul_b = ud; end
      S_MUL1: begin mul_a = uw; mul_b = uw; end
      default: begin mul_a = ua; mul_b = uw; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign shifted = {rem[66:0], nlo[31]};
  assign ge      = shifted >= {1'b0, den};
  assign tmag    = sat_mag(q, over, neg);
  assign term    = neg ? -$signed(SUM_W'(tmag)) : $signed(SUM_W'(tmag));

  always_ff @(posedge clk) begin
    if (load_we) begin
      peak <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (tok_in.valid) begin
            if (!en) begin
              tok_out <= tok_in;
            end else begin
              x <= tok_in.x;
              sum <= tok_in.sum;
              err <= tok_in.err;
              ud <= ud_in;
              state <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          d2 <= prod;
          state <= S_MUL1;
        end
        S_MUL1: begin
          w2 <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          n <= prod;
          state <= S_DEN;
        end
        S_DEN: begin
          den <= {1'b0, d2, 2'b00} + {3'b000, w2};
          state <= S_CHK;
        end
        S_CHK: begin
          over <= 1'b0;
          q <= '0;
          if (den == '0) begin
            err <= 1'b1;
            state <= S_ACC;
          end else if ({19'b0, n} >= {den, 16'b0}) begin
            over <= 1'b1;
            state <= S_ACC;
          end else begin
            rem <= {20'b0, n[63:16]};
            nlo <= {n[15:0], 16'b0};
            cnt <= 5'd31;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? (shifted - {1'b0, den}) : shifted;
          q <= {q[30:0], ge};
          nlo <= {nlo[30:0], 1'b0};
          if (cnt == '0) begin
            state <= S_ACC;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_ACC: begin
          tok_out.valid <= 1'b1;
          tok_out.x <= x;
          tok_out.sum <= sum + term;
          tok_out.err <= err;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/lrz_resid.sv =====
// Residual tail: offset, sigma division, saturation and chi-square sum.
module lrz_resid (
  input  logic               clk,
  input  logic               rst,
  input  lrz_pkg::tok_t      tok_in,
  input  logic signed [31:0] offset,
  input  logic signed [31:0] y,
  input  logic [30:0]        sigma,
  input  logic               last,
  input  logic               result_stall,
  output logic               result_valid,
  output lrz_pkg::result_t   result,
  output logic               done
);
  import lrz_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_DIV, S_SAT, S_SQ, S_OUT} state_t;

  state_t state;
  logic signed [SUM_W-1:0] s;
  logic err;
  logic [31:0] rem;
  logic [31:0] nlo;
  logic [31:0] q;
  logic over;
  logic [4:0] cnt;
  logic [31:0] rmag;
  logic [31:0] res;
  logic [63:0] sq;
  logic [63:0] chi;

  logic [SUM_W-1:0] smag;
  logic neg;
  logic [31:0] shifted;
  logic ge;
  logic [31:0] qmag;
  logic [64:0] chi_add;
  logic [63:0] chi_next;

  assign neg      = s[SUM_W-1];
  assign smag     = neg ? $unsigned(-s) : $unsigned(s);
  assign shifted  = {rem[30:0], nlo[31]};
  assign ge       = shifted >= {1'b0, sigma};
  assign qmag     = sat_mag(q, over, neg);
  assign chi_add  = {1'b0, chi} + {1'b0, sq};
  assign chi_next = chi_add[64] ? '1 : chi_add[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      done <= 1'b0;
      chi <= '0;
    end else begin
      done <= 1'b0;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tok_in.valid) begin
            s <= tok_in.sum + SUM_W'(offset) - SUM_W'(y);
            err <= tok_in.err;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          over <= 1'b0;
          q <= '0;
          if (sigma == '0) begin
            err <= 1'b1;
            state <= S_SAT;
          end else if ({7'b0, smag} >= {sigma, 16'b0}) begin
            over <= 1'b1;
            state <= S_SAT;
          end else begin
            rem <= {8'b0, smag[SUM_W-1:16]};
            nlo <= {smag[15:0], 16'b0};
            cnt <= 5'd31;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? (shifted - {1'b0, sigma}) : shifted;
          q <= {q[30:0], ge};
          nlo <= {nlo[30:0], 1'b0};
          if (cnt == '0) begin
            state <= S_SAT;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_SAT: begin
          rmag <= qmag;
          res <= neg ? -qmag : qmag;
          state <= S_SQ;
        end
        S_SQ: begin
          sq <= rmag * rmag;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            result.residual <= res;
            result.chi_square <= chi_next;
            result.point_last <= last;
            result.divide_error <= err;
            chi <= last ? '0 : chi_next;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/sv/lorentz_multi_peak_residual_checker.sv =====
// Result predictor and comparator for the Lorentzian residual engine.
`timescale 1ns / 100ps

module lorentz_multi_peak_residual_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  lrz_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  lrz_pkg::result_t result,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [31:0]      wr_data,
  output int               errors,
  output int               pending,
  output int               results_seen
);
  import lrz_pkg::*;

  peak_t          peaks [NUM_PEAKS];
  logic [4:0]     npeaks;
  logic signed [31:0] baseline;
  logic [63:0]    chi_acc;
  result_t        expected_q [$];

  function automatic longint lorentz_term(logic signed [31:0] x, peak_t pk, ref bit err);
    longint d;
    logic [127:0] ud, uw, ua, den, q;
    logic neg;
    d = longint'(x) - longint'(pk.ctr);
    ud = (d < 0) ? -d : d;
    uw = (pk.wid < 0) ? -longint'(pk.wid) : longint'(pk.wid);
    ua = (pk.amp < 0) ? -longint'(pk.amp) : longint'(pk.amp);
    den = ((ud * ud) << 2) + uw * uw;
    if (den == 0) begin
      err = 1'b1;
      return 0;
    end
    q = ((ua * uw) << 16) / den;
    neg = (pk.amp < 0) != (pk.wid < 0);
    if (neg && q > 128'h8000_0000) q = 128'h8000_0000;
    if (!neg && q > 128'h7fff_ffff) q = 128'h7fff_ffff;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic result_t predict_point(item_t it);
    result_t r;
    bit err;
    longint acc;
    int n;
    logic [127:0] mag;
    logic [63:0] sq;
    logic [64:0] tot;
    logic signed [31:0] res;
    err = 1'b0;
    res = '0;
    n = (npeaks > NUM_PEAKS) ? NUM_PEAKS : npeaks;
    acc = 0;
    for (int k = 0; k < n; k++) acc += lorentz_term(it.x_value, peaks[k], err);
    acc += longint'(baseline) - longint'(it.y_value);
    if (it.sigma_value == 0) begin
      err = 1'b1;
    end else begin
      mag = (128'((acc < 0) ? -acc : acc) << 16) / it.sigma_value;
      if (acc < 0) begin
        if (mag > 128'h8000_0000) mag = 128'h8000_0000;
        res = 32'(-longint'(mag));
      end else begin
        if (mag > 128'h7fff_ffff) mag = 128'h7fff_ffff;
        res = mag[31:0];
      end
    end
    mag = (res < 0) ? -longint'(res) : longint'(res);
    sq = mag[63:0] * mag[63:0];
    tot = {1'b0, chi_acc} + sq;
    chi_acc = tot[64] ? '1 : tot[63:0];
    r.residual = res;
    r.chi_square = chi_acc;
    r.point_last = it.last_point;
    r.divide_error = err;
    if (it.last_point) chi_acc = '0;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      npeaks <= 5'd1;
      baseline <= '0;
      chi_acc = '0;
      expected_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_PEAK_COUNT) npeaks <= wr_data[4:0];
        else baseline <= wr_data;
      end
      if (item_valid && !item_stall) begin
        if (item.cmd == CMD_LOAD) begin
          peaks[item.peak_index].amp <= item.peak_amplitude;
          peaks[item.peak_index].ctr <= item.peak_center;
          peaks[item.peak_index].wid <= item.peak_width;
        end else begin
          expected_q.push_back(predict_point(item));
        end
      end
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: residual %0d", result.residual);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.residual !== result.residual ||
              e.chi_square !== result.chi_square ||
              e.point_last !== result.point_last ||
              e.divide_error !== result.divide_error) begin
            errors <= errors + 1;
            if (e.residual !== result.residual)
              $error("residual: expected %0d actual %0d", e.residual, result.residual);
            if (e.chi_square !== result.chi_square)
              $error("chi_square: expected %h actual %h", e.chi_square, result.chi_square);
            if (e.point_last !== result.point_last)
              $error("point_last: expected %b actual %b", e.point_last, result.point_last);
            if (e.divide_error !== result.divide_error)
              $error("divide_error: expected %b actual %b",
                     e.divide_error, result.divide_error);
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/lorentz_multi_peak_residual_test.sv =====
// Stimulus and verdict for the Lorentzian residual engine.
`timescale 1ns / 100ps

module lorentz_multi_peak_residual_test;
  import lrz_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic wr_en = 1'b0;
  logic wr_index = REG_PEAK_COUNT;
  logic [31:0] wr_data = '0;
  int errors, pending, results_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int points_sent = 0;

  always #1 clk = ~clk;

  lorentz_multi_peak_residual DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  lorentz_multi_peak_residual_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic logic signed [31:0] rnd_q();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  task automatic send_beat(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (it.cmd == CMD_POINT) points_sent++;
  endtask

  task automatic load_peak(int idx, logic signed [31:0] a, logic signed [31:0] c,
                           logic signed [31:0] w);
    item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.peak_index = IDX_W'(idx);
    it.peak_amplitude = a;
    it.peak_center = c;
    it.peak_width = w;
    it.x_value = $urandom;
    send_beat(it);
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic [30:0] s, logic lst);
    item_t it;
    it = '0;
    it.cmd = CMD_POINT;
    it.x_value = x;
    it.y_value = y;
    it.sigma_value = s;
    it.last_point = lst;
    it.peak_amplitude = $urandom;
    send_beat(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_beat();
    logic [30:0] s;
    if ($urandom_range(0, 99) < 15) begin
      load_peak($urandom_range(0, NUM_PEAKS - 1), rnd_q(), rnd_q(), rnd_q());
    end else begin
      s = 31'($urandom >> $urandom_range(1, 31));
      if ($urandom_range(0, 19) == 0) s = '0;
      send_point(rnd_q(), rnd_q(), s, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    logic [4:0] counts [6];
    logic [31:0] offsets [6];
    counts = '{5'd1, 5'd0, 5'd3, 5'd16, 5'd31, 5'd7};
    offsets = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, $urandom, $urandom, 32'h0001_0000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill the table, then corner points
    load_peak(0, 32'sh7fff_ffff, 32'sh0, 32'sh0);
    load_peak(1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    load_peak(2, 32'sh0001_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    for (int k = 3; k < NUM_PEAKS; k++)
      load_peak(k, rnd_q(), rnd_q(), rnd_q());
    send_point(32'sh0, 32'sh0, 31'h1, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff, 1'b0);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 31'h0, 1'b0);
    send_point(32'sh0, 32'sh7fff_ffff, 31'h1, 1'b0);
    send_point(32'sh0001_0000, 32'sh0, 31'h0001_0000, 1'b1);
    send_point(32'sh0, 32'sh0, 31'h1, 1'b1);
    drain();
    write_reg(REG_PEAK_COUNT, 32'd16);
    send_point(32'sh7fff_ffff, 32'sh0, 31'h1, 1'b0);
    send_point(32'sh8000_0000, 32'sh0, 31'h4000_0000, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_PEAK_COUNT, {27'd0, counts[ph]});
      write_reg(REG_OFFSET, offsets[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int i = 0; i < 165; i++) random_beat();
    end

    drain();
    repeat (700) @(posedge clk);
    $display("Run covered %0d beats in, %0d data points, %0d results checked,",
             items_sent, points_sent, results_seen);
    $display("over six peak-count/offset settings and four idle patterns.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== lorentz_multi_peak_residual.f =====
+incdir+design
design/lrz_pkg.sv
design/lrz_cell.sv
design/lrz_resid.sv
design/lorentz_multi_peak_residual.sv
tb/sv/lorentz_multi_peak_residual_checker.sv
tb/sv/lorentz_multi_peak_residual_test.sv
